// ===== design/nesq_pkg.sv =====
// ----------------------------------------------------------------------------
// nesq_pkg
// Shared types and codes of the note event step sequencer.
// ----------------------------------------------------------------------------
package nesq_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic EV_TRIGGER = 1'b0;
  localparam logic EV_RELEASE = 1'b1;

  localparam logic CFG_LOOP_ENABLE = 1'b0;
  localparam logic CFG_LOOP_TICKS  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_FLUSH
  } nesq_state_e;

  typedef struct packed {
    logic [16:0] start;
    logic [15:0] length;
    logic [6:0]  note;
  } nesq_entry_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] note;
    logic [4:0] entry;
  } nesq_event_t;

endpackage

// ===== design/note_event_step_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// note_event_step_sequencer_top
// Note table in a synchronous memory; a tick scans one slot per cycle unless held.
// ----------------------------------------------------------------------------
// write request: accepted while idle, and ready does not drop
// tick request: busy for the scan of every slot and the flush, longer for each slot
//   that fires both events and for any output-side stalls; none is taken meanwhile
// events wait in a pending register until the next event or the flush; the last
//   event of a scan is flagged with last_event_o
// reset: tick counter zero, all slots disabled, looping off, loop of 16 ticks
module note_event_step_sequencer_top
  import nesq_pkg::*;
#(
  parameter int MAX_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [4:0]  entry_index_i,
  input  logic        entry_valid_i,
  input  logic [15:0] block_offset_i,
  input  logic [15:0] note_offset_i,
  input  logic [15:0] note_length_i,
  input  logic [6:0]  note_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        event_kind_o,
  output logic [6:0]  event_note_o,
  output logic [4:0]  event_entry_o,
  output logic        last_event_o
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_ENTRIES - 1);

  nesq_state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic phase_q, phase_d;
  logic [31:0] tick_q, tick_d;
  logic loop_en_q;
  logic [15:0] loop_ticks_q;
  logic [MAX_ENTRIES-1:0] en_q, en_d;

  nesq_entry_t mem_q [MAX_ENTRIES];
  nesq_entry_t rdata_q;
  logic mem_we;
  logic [IdxW-1:0] mem_waddr;
  nesq_entry_t mem_wdata;
  logic rd_en;
  logic [IdxW-1:0] rd_addr;

  nesq_event_t pend_q, pend_d;
  logic have_pend_q, have_pend_d;
  nesq_event_t out_q, out_d;
  logic out_last_q, out_last_d;
  logic out_valid_q, out_valid_d;
  logic out_load;

  logic in_accept;
  logic slot_ok;
  logic out_free;
  logic push_ok;
  logic trig_hit, rel_hit;
  logic cand_match;
  nesq_event_t cand;
  logic [17:0] rel_sum;
  logic [31:0] tick_inc;
  logic [31:0] tick_next;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  assign slot_ok    = ({1'b0, entry_index_i} < 6'(MAX_ENTRIES));
  assign out_free   = !out_valid_q || out_ready_i;
  assign push_ok    = !have_pend_q || out_free;

  assign rel_sum  = {1'b0, rdata_q.start} + {2'b00, rdata_q.length};
  assign trig_hit = en_q[idx_q] && ({15'b0, rdata_q.start} == tick_q);
  assign rel_hit  = en_q[idx_q] && ({14'b0, rel_sum} == tick_q);

  assign tick_inc  = tick_q + 32'd1;
  assign tick_next = (loop_en_q && (tick_inc >= {16'b0, loop_ticks_q})) ? 32'd0 : tick_inc;

  always_comb begin
    cand.note  = rdata_q.note;
    cand.entry = 5'(idx_q);
    if (phase_q) begin
      cand.kind  = EV_RELEASE;
      cand_match = 1'b1;
    end else begin
      cand.kind  = trig_hit ? EV_TRIGGER : EV_RELEASE;
      cand_match = trig_hit || rel_hit;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    tick_d      = tick_q;
    en_d        = en_q;
    pend_d      = pend_q;
    have_pend_d = have_pend_q;
    out_load    = 1'b0;
    out_d       = pend_q;
    out_last_d  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = entry_index_i[IdxW-1:0];
    mem_wdata   = '{start: {1'b0, block_offset_i} + {1'b0, note_offset_i},
                    length: note_length_i, note: note_value_i};
    rd_en       = 1'b0;
    rd_addr     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (op_i == OP_WRITE) begin
            if (slot_ok) begin
              mem_we = 1'b1;
              en_d[entry_index_i[IdxW-1:0]] = entry_valid_i;
            end
          end else begin
            rd_en       = 1'b1;
            rd_addr     = '0;
            idx_d       = '0;
            phase_d     = 1'b0;
            have_pend_d = 1'b0;
            state_d     = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (!(cand_match && !push_ok)) begin
          if (cand_match) begin
            if (have_pend_q) begin
              out_load = 1'b1;
            end
            pend_d      = cand;
            have_pend_d = 1'b1;
          end
          if (!phase_q && trig_hit && rel_hit) begin
            phase_d = 1'b1;
          end else begin
            phase_d = 1'b0;
            if (idx_q == LastIdx) begin
              state_d = S_FLUSH;
            end else begin
              idx_d   = idx_q + 1'b1;
              rd_en   = 1'b1;
              rd_addr = idx_q + 1'b1;
            end
          end
        end
      end
      S_FLUSH: begin
        if (!have_pend_q) begin
          tick_d  = tick_next;
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load    = 1'b1;
          out_last_d  = 1'b1;
          have_pend_d = 1'b0;
          tick_d      = tick_next;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      phase_q      <= 1'b0;
      tick_q       <= '0;
      en_q         <= '0;
      have_pend_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      loop_en_q    <= 1'b0;
      loop_ticks_q <= 16'd16;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      en_q        <= en_d;
      have_pend_q <= have_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOOP_ENABLE: loop_en_q <= cfg_wdata_i[0];
          CFG_LOOP_TICKS:  loop_ticks_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) begin
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  // note table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_q.kind;
  assign event_note_o  = out_q.note;
  assign event_entry_o = out_q.entry;
  assign last_event_o  = out_last_q;

  a_pend_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_pend_q |-> (state_q != S_IDLE))
    else $error("pending event outside a scan");

  a_tick_moves_at_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FLUSH) |=> $stable(tick_q))
    else $error("tick changed outside the end of a scan");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("output event overwritten before it was taken");

  a_last_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (state_q == S_IDLE) && !have_pend_q)
    else $error("last event did not close the scan");

endmodule
